### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Transaction types, character codes and precedence helpers for the
// infix to prefix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       out_last;
      logic       unmatched_paren;
      logic       truncated;
   } rsp_payload_type;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_DIG_0  = 8'h30;
   localparam logic [7:0] CH_DIG_9  = 8'h39;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      p = 2'd0;
      if (c == CH_PLUS || c == CH_MINUS) begin
         p = 2'd1;
      end else if (c == CH_STAR || c == CH_SLASH) begin
         p = 2'd2;
      end else if (c == CH_CARET) begin
         p = 2'd3;
      end
      return p;
   endfunction

   function automatic logic is_operand(input logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             (c >= CH_DIG_0 && c <= CH_DIG_9);
   endfunction

endpackage

### src/itp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module itp_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/infix_to_prefix_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_prefix_converter_core
// Shunting-yard infix to prefix converter built round an expression RAM,
// which also holds the result, and an operator stack RAM.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction | transaction
//  req     | req_valid req_stall req_payload    | in        | one infix byte
//  rsp     | rsp_valid rsp_stall rsp_payload    | out       | one prefix byte
//
//  Loading accepts one byte per cycle; req_stall is low only while loading.
//  Conversion reads each stored byte from the expression RAM, then executes
//  it; each operator popped adds an execute step, fed by the stack RAM read.
//  Output reads each result item from the RAM, then presents it, held while
//  rsp_stall is high. Synchronous reset returns to loading.
// ----------------------------------------------------------------------------
module infix_to_prefix_converter_core #(
   parameter int MAX_LEN = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  itp_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output itp_pkg::rsp_payload_type  rsp_payload
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] TWO = CW'(2);
   localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

   localparam logic [2:0] ST_LOAD     = 3'd0;
   localparam logic [2:0] ST_SCAN_RD  = 3'd1;
   localparam logic [2:0] ST_EXEC     = 3'd2;
   localparam logic [2:0] ST_DRAIN    = 3'd3;
   localparam logic [2:0] ST_OUT_RD   = 3'd4;
   localparam logic [2:0] ST_OUT_SHOW = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] res_ff, res_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [CW-1:0] optr_ff, optr_in;
   logic [7:0]    top_ff, top_in;
   logic          top_mem_ff, top_mem_in;
   logic          ovf_ff, ovf_in;
   logic          unf_ff, unf_in;

   logic          buf_we, buf_re;
   logic [AW-1:0] buf_waddr, buf_raddr;
   logic [7:0]    buf_wdata, buf_rdata;
   logic          stk_we, stk_re;
   logic [AW-1:0] stk_waddr, stk_raddr;
   logic [7:0]    stk_wdata, stk_rdata;

   logic [7:0]    top_w;
   logic [7:0]    cur;
   logic [CW-1:0] emit_addr;
   logic [CW-1:0] sp_less1;
   logic [CW-1:0] sp_less2;
   logic [CW-1:0] out_addr;
   logic [CW-1:0] scan_addr;
   logic          rsp_last;

   itp_ram #(.DEPTH(MAX_LEN), .WIDTH(8)) u_expr_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_en   (buf_re),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   itp_ram #(.DEPTH(MAX_LEN), .WIDTH(8)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign top_w     = top_mem_ff ? stk_rdata : top_ff;
   assign cur       = buf_rdata;
   assign emit_addr = len_ff - res_ff - ONE;
   assign sp_less1  = sp_ff - ONE;
   assign sp_less2  = sp_ff - TWO;
   assign out_addr  = len_ff - res_ff + optr_ff;
   assign scan_addr = idx_ff - ONE;
   assign rsp_last  = (res_ff == '0) || ((optr_ff + ONE) == res_ff);

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_OUT_SHOW);

   always_comb begin
      rsp_payload.out_char        = (res_ff == '0) ? 8'h00 : buf_rdata;
      rsp_payload.char_valid      = (res_ff != '0);
      rsp_payload.out_last        = rsp_last;
      rsp_payload.unmatched_paren = unf_ff;
      rsp_payload.truncated       = ovf_ff;
   end

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      res_in     = res_ff;
      sp_in      = sp_ff;
      optr_in    = optr_ff;
      top_in     = top_ff;
      top_mem_in = top_mem_ff;
      ovf_in     = ovf_ff;
      unf_in     = unf_ff;
      buf_we     = 1'b0;
      buf_waddr  = emit_addr[AW-1:0];
      buf_wdata  = top_w;
      buf_re     = 1'b0;
      buf_raddr  = scan_addr[AW-1:0];
      stk_we     = 1'b0;
      stk_waddr  = sp_less1[AW-1:0];
      stk_wdata  = top_w;
      stk_re     = 1'b0;
      stk_raddr  = sp_less2[AW-1:0];

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (len_ff < LEN_MAX) begin
                  buf_we    = 1'b1;
                  buf_waddr = len_ff[AW-1:0];
                  buf_wdata = req_payload.in_char;
                  len_in    = len_ff + ONE;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.in_last) begin
                  idx_in   = len_in;
                  sp_in    = '0;
                  res_in   = '0;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               buf_re   = 1'b1;
               idx_in   = scan_addr;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (itp_pkg::is_operand(cur)) begin
               buf_we    = 1'b1;
               buf_wdata = cur;
               res_in    = res_ff + ONE;
               state_in  = ST_SCAN_RD;
            end else if (cur == itp_pkg::CH_LPAREN) begin
               if (sp_ff == '0) begin
                  unf_in   = 1'b1;
                  state_in = ST_SCAN_RD;
               end else begin
                  sp_in = sp_less1;
                  if (sp_ff >= TWO) begin
                     stk_re     = 1'b1;
                     top_mem_in = 1'b1;
                  end
                  if (top_w == itp_pkg::CH_RPAREN) begin
                     state_in = ST_SCAN_RD;
                  end else begin
                     buf_we = 1'b1;
                     res_in = res_ff + ONE;
                  end
               end
            end else if (cur != itp_pkg::CH_RPAREN && sp_ff != '0 &&
                         itp_pkg::prec_of(cur) < itp_pkg::prec_of(top_w)) begin
               buf_we = 1'b1;
               res_in = res_ff + ONE;
               sp_in  = sp_less1;
               if (sp_ff >= TWO) begin
                  stk_re     = 1'b1;
                  top_mem_in = 1'b1;
               end
            end else begin
               stk_we     = (sp_ff != '0);
               top_in     = cur;
               top_mem_in = 1'b0;
               sp_in      = sp_ff + ONE;
               state_in   = ST_SCAN_RD;
            end
         end
         ST_DRAIN: begin
            if (sp_ff != '0) begin
               buf_we = 1'b1;
               res_in = res_ff + ONE;
               sp_in  = sp_less1;
               if (sp_ff >= TWO) begin
                  stk_re     = 1'b1;
                  top_mem_in = 1'b1;
               end
            end else begin
               optr_in  = '0;
               state_in = (res_ff == '0) ? ST_OUT_SHOW : ST_OUT_RD;
            end
         end
         ST_OUT_RD: begin
            buf_re    = 1'b1;
            buf_raddr = out_addr[AW-1:0];
            state_in  = ST_OUT_SHOW;
         end
         ST_OUT_SHOW: begin
            if (!rsp_stall) begin
               if (rsp_last) begin
                  len_in   = '0;
                  res_in   = '0;
                  sp_in    = '0;
                  ovf_in   = 1'b0;
                  unf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  optr_in  = optr_ff + ONE;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         len_ff     <= '0;
         idx_ff     <= '0;
         res_ff     <= '0;
         sp_ff      <= '0;
         optr_ff    <= '0;
         top_mem_ff <= 1'b0;
         ovf_ff     <= 1'b0;
         unf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         res_ff     <= res_in;
         sp_ff      <= sp_in;
         optr_ff    <= optr_in;
         top_mem_ff <= top_mem_in;
         ovf_ff     <= ovf_in;
         unf_ff     <= unf_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

endmodule

### src/itp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the converter's request and response channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input itp_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input itp_pkg::rsp_payload_type rsp_payload
);

   `ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped while stalled")

   `ASSERT_NEXT(a_rsp_payload_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload), "rsp_payload changed while stalled")

   `ASSERT_IMPLY(a_no_load_in_output, clock, reset, rsp_valid, req_stall, "request taken during output")

   `ASSERT_IMPLY(a_empty_is_last, clock, reset, rsp_valid && !rsp_payload.char_valid, rsp_payload.out_last, "empty result not marked last")

   `ASSERT_NEXT(a_last_in_starts_work, clock, reset, req_valid && !req_stall && req_payload.in_last, req_stall, "conversion did not start after last byte")

endmodule

bind infix_to_prefix_converter_core itp_checker u_itp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the infix to prefix converter. Expressions are
// sent a byte at a time and each prefix character that comes back is
// compared with an in-bench shunting-yard predictor. Directed cases cover
// operator precedence, bracket handling, empty results and byte extremes.
// The random part sends mostly well-formed expressions with noise and
// broken brackets mixed in. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int EXPR_MAX     = 64;
   localparam int ITEM_TARGET  = 210;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 300;
   localparam int PRINT_CAP    = 40;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   itp_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   itp_pkg::rsp_payload_type rsp_payload;

   // predictor state
   logic [7:0]               stored_expr [EXPR_MAX];
   int                       stored_len;
   logic                     stored_truncated;
   itp_pkg::rsp_payload_type prefix_expected [$];

   logic [7:0]               expr_text [$];
   int                       gap_max;
   int                       stall_max;
   int                       stall_left;
   int                       items_sent;
   int                       expressions_sent;
   int                       chars_checked = 0;
   int                       mismatches = 0;
   int                       cycle_count = 0;

   infix_to_prefix_converter_core #(
      .MAX_LEN(EXPR_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  prefix_expected.size());
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [1:0] op_rank(input logic [7:0] c);
      case (c)
         itp_pkg::CH_PLUS, itp_pkg::CH_MINUS:  return 2'd1;
         itp_pkg::CH_STAR, itp_pkg::CH_SLASH:  return 2'd2;
         itp_pkg::CH_CARET:                    return 2'd3;
         default:                              return 2'd0;
      endcase
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= itp_pkg::CH_LO_A && c <= itp_pkg::CH_LO_Z) ||
             (c >= itp_pkg::CH_UP_A && c <= itp_pkg::CH_UP_Z) ||
             (c >= itp_pkg::CH_DIG_0 && c <= itp_pkg::CH_DIG_9);
   endfunction

   // scan the stored expression from the end and queue the prefix characters
   function automatic void predict_prefix();
      logic [7:0]               pending_ops [$];
      logic [7:0]               scan_out [$];
      logic                     paren_miss;
      logic [7:0]               c;
      itp_pkg::rsp_payload_type item;
      int                       i;
      int                       k;
      paren_miss = 1'b0;
      for (i = stored_len - 1; i >= 0; i--) begin
         c = stored_expr[i];
         if (is_alnum(c)) begin
            scan_out.push_back(c);
         end else if (c == itp_pkg::CH_RPAREN) begin
            pending_ops.push_back(c);
         end else if (c == itp_pkg::CH_LPAREN) begin
            while (pending_ops.size() > 0 && pending_ops[$] != itp_pkg::CH_RPAREN)
               scan_out.push_back(pending_ops.pop_back());
            if (pending_ops.size() > 0) begin
               void'(pending_ops.pop_back());
            end else begin
               paren_miss = 1'b1;
            end
         end else begin
            while (pending_ops.size() > 0 && op_rank(c) < op_rank(pending_ops[$]))
               scan_out.push_back(pending_ops.pop_back());
            pending_ops.push_back(c);
         end
      end
      while (pending_ops.size() > 0)
         scan_out.push_back(pending_ops.pop_back());

      item.unmatched_paren = paren_miss;
      item.truncated       = stored_truncated;
      if (scan_out.size() == 0) begin
         item.out_char   = '0;
         item.char_valid = 1'b0;
         item.out_last   = 1'b1;
         prefix_expected.push_back(item);
      end else begin
         for (k = scan_out.size() - 1; k >= 0; k--) begin
            item.out_char   = scan_out[k];
            item.char_valid = 1'b1;
            item.out_last   = (k == 0);
            prefix_expected.push_back(item);
         end
      end
   endfunction

   function automatic void store_byte(input logic [7:0] ch, input logic last);
      if (stored_len < EXPR_MAX) begin
         stored_expr[stored_len] = ch;
         stored_len++;
      end else begin
         stored_truncated = 1'b1;
      end
      if (last) begin
         predict_prefix();
         stored_len       = 0;
         stored_truncated = 1'b0;
         expressions_sent++;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("mismatch: %s got %02h expected %02h at result %0d", what, got, want,
                  chars_checked);
   endtask

   // check each accepted result and draw the stall before the next one
   always @(posedge clock) begin
      itp_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (prefix_expected.size() == 0) begin
               report_mismatch("unexpected result, out_char", rsp_payload.out_char, '0);
            end else begin
               want = prefix_expected.pop_front();
               if (rsp_payload.out_char !== want.out_char)
                  report_mismatch("out_char", rsp_payload.out_char, want.out_char);
               if (rsp_payload.char_valid !== want.char_valid)
                  report_mismatch("char_valid", 8'(rsp_payload.char_valid),
                                  8'(want.char_valid));
               if (rsp_payload.out_last !== want.out_last)
                  report_mismatch("out_last", 8'(rsp_payload.out_last), 8'(want.out_last));
               if (rsp_payload.unmatched_paren !== want.unmatched_paren)
                  report_mismatch("unmatched_paren", 8'(rsp_payload.unmatched_paren),
                                  8'(want.unmatched_paren));
               if (rsp_payload.truncated !== want.truncated)
                  report_mismatch("truncated", 8'(rsp_payload.truncated),
                                  8'(want.truncated));
            end
            chars_checked++;
            stall_left = $urandom_range(0, stall_max);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   task automatic send_byte(input logic [7:0] ch, input logic last);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{in_char: ch, in_last: last};
      do @(posedge clock); while (req_stall);
      store_byte(ch, last);
      items_sent++;
   endtask

   task automatic send_expression();
      int i;
      for (i = 0; i < expr_text.size(); i++)
         send_byte(expr_text[i], i == expr_text.size() - 1);
   endtask

   task automatic send_text(input string s);
      int i;
      expr_text.delete();
      for (i = 0; i < s.len(); i++)
         expr_text.push_back(s[i]);
      send_expression();
   endtask

   task automatic pick_idling();
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 15;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
   endtask

   function automatic logic [7:0] any_operand();
      case ($urandom_range(0, 2))
         0:       return itp_pkg::CH_LO_A + 8'($urandom_range(0, 25));
         1:       return itp_pkg::CH_UP_A + 8'($urandom_range(0, 25));
         default: return itp_pkg::CH_DIG_0 + 8'($urandom_range(0, 9));
      endcase
   endfunction

   function automatic logic [7:0] any_operator();
      case ($urandom_range(0, 4))
         0:       return itp_pkg::CH_PLUS;
         1:       return itp_pkg::CH_MINUS;
         2:       return itp_pkg::CH_STAR;
         3:       return itp_pkg::CH_SLASH;
         default: return itp_pkg::CH_CARET;
      endcase
   endfunction

   // exactly target bytes, brackets closed, mostly well-formed
   function automatic void make_expression(input int target);
      int   depth;
      int   room;
      logic want_operand;
      expr_text.delete();
      depth        = 0;
      want_operand = 1'b1;
      while (expr_text.size() < target) begin
         room = target - expr_text.size();
         if (want_operand) begin
            if (room >= depth + 4 && $urandom_range(0, 3) == 0) begin
               expr_text.push_back(itp_pkg::CH_LPAREN);
               depth++;
            end else begin
               expr_text.push_back(any_operand());
               want_operand = 1'b0;
            end
         end else if (depth > 0 && (room < depth + 2 || $urandom_range(0, 2) == 0)) begin
            expr_text.push_back(itp_pkg::CH_RPAREN);
            depth--;
         end else if (room >= depth + 2) begin
            expr_text.push_back(any_operator());
            want_operand = 1'b1;
         end else begin
            expr_text.push_back(any_operand());
         end
      end
   endfunction

   task automatic test_precedence();
      gap_max   = 15;
      stall_max = 15;
      send_text("(a+b)*c");
      send_text("x-Y/z^9");
   endtask

   task automatic test_brackets();
      send_text("(");
      send_text("()");
      send_text(")");
      send_text("a(b");
   endtask

   task automatic test_byte_extremes();
      gap_max   = 0;
      stall_max = 0;
      send_byte('0, 1'b1);
      send_byte('1, 1'b1);
   endtask

   task automatic test_length_limit();
      pick_idling();
      make_expression(EXPR_MAX);
      send_expression();
      pick_idling();
      make_expression(EXPR_MAX + 3);
      send_expression();
   endtask

   task automatic test_random_mix();
      int pos;
      while (items_sent < ITEM_TARGET) begin
         pick_idling();
         case ($urandom_range(0, 9))
            0: begin
               expr_text.delete();
               repeat ($urandom_range(1, 6)) expr_text.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
               make_expression($urandom_range(2, 12));
               pos = $urandom_range(0, expr_text.size() - 1);
               if ($urandom_range(0, 1)) begin
                  expr_text.insert(pos, $urandom_range(0, 1) ? itp_pkg::CH_LPAREN
                                                             : itp_pkg::CH_RPAREN);
               end else begin
                  expr_text.delete(pos);
               end
            end
            default: make_expression($urandom_range(1, 15));
         endcase
         send_expression();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      gap_max          = 0;
      stall_max        = 0;
      stored_len       = 0;
      stored_truncated = 1'b0;
      items_sent       = 0;
      expressions_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_precedence();
      test_brackets();
      test_byte_extremes();
      test_length_limit();
      test_random_mix();
      req_valid <= 1'b0;

      while (prefix_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d bytes in %0d expressions, %0d prefix characters checked",
               items_sent, expressions_sent, chars_checked);
      $display("summary: %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/itp_pkg.sv
src/itp_ram.sv
src/infix_to_prefix_converter_core.sv
src/itp_checker.sv
tb/testbench.sv
